/* sv/rsps_pkg.sv */
// Shared types and constants for the range sensor poll supervisor.
// No dependencies; the top level and the testbench import this package.
package rsps_pkg;

  // Event codes on the request channel.
  localparam logic [1:0] OP_POLL    = 2'd0;
  localparam logic [1:0] OP_BRINGUP = 2'd1;
  localparam logic [1:0] OP_REINIT  = 2'd2;

  // Sensor status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOSENS = 3'd1;
  localparam logic [2:0] ST_ERR    = 3'd2;
  localparam logic [2:0] ST_STALL  = 3'd3;
  localparam logic [2:0] ST_DISC   = 3'd4;

  // Data word kinds.
  localparam logic [2:0] DK_DIST   = 3'd0;
  localparam logic [2:0] DK_NOSENS = 3'd1;
  localparam logic [2:0] DK_DISC   = 3'd2;
  localparam logic [2:0] DK_ERR    = 3'd3;
  localparam logic [2:0] DK_STALL  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BUS_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_STALL_TMO   = 3'd1;
  localparam logic [2:0] CFG_RESTART_TMO = 3'd2;
  localparam logic [2:0] CFG_RESET_TMO   = 3'd3;
  localparam logic [2:0] CFG_RECOVER_GAP = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] STALL_TMO_RST   = 16'd200;
  localparam logic [15:0] RESTART_TMO_RST = 16'd2000;
  localparam logic [15:0] RESET_TMO_RST   = 16'd10000;
  localparam logic [15:0] RECOVER_GAP_RST = 16'd2000;

  // Reading limits.
  localparam logic [15:0] RAW_MAX  = 16'd200;
  localparam logic [15:0] CLAMP_LO = 16'd5;
  localparam logic [15:0] CLAMP_HI = 16'd50;
  localparam logic [5:0]  DIST_MAX = 6'd50;

  // A bus recovery is considered on a silent poll whenever the streak is a multiple of STREAK_PERIOD.
  localparam int STREAK_PERIOD = 10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  channel;
    logic [31:0] now_ms;
    logic        bus_error;
    logic        data_ready;
    logic        result_good;
    logic [15:0] raw_mm;
    logic        outcome_ok;
  } req_t;

  typedef struct packed {
    logic [4:0] channel_out;
    logic       data_updated;
    logic [2:0] data_kind;
    logic [5:0] distance_out;
    logic [2:0] sensor_status;
    logic       restart_request;
    logic       hard_reset_request;
    logic       bus_recover_request;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_t;

  // One entry of the per-channel state memory.
  typedef struct packed {
    logic        online;
    logic        ever_online;
    logic [2:0]  status;
    logic [7:0]  streak;
    logic [31:0] last_good;
    logic [5:0]  filt;
    logic        loaded;
  } ch_state_t;

  localparam ch_state_t CH_STATE_RST = '{
    online:      1'b0,
    ever_online: 1'b0,
    status:      ST_NOSENS,
    streak:      8'd0,
    last_good:   32'd0,
    filt:        6'd0,
    loaded:      1'b0
  };

  // True when an 8-bit streak count is a multiple of STREAK_PERIOD.
  function automatic logic streak_hits(logic [7:0] x);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k * STREAK_PERIOD < 256; k++) begin
      if (x == 8'(k * STREAK_PERIOD)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* sv/rsps_stream_if.sv */
// Valid/ready channel carrying one payload type.
// Depends on nothing; payload types come from rsps_pkg at instantiation.
interface rsps_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/rsps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/range_sensor_poll_supervisor.sv */
// Range sensor poll supervisor: top level. Uses rsps_pkg, rsps_stream_if and rsps_ram.
// A taken request waits in stage 1, then its answer is held in the result register.
// Throughput: one request per cycle unless the receiver stalls, set by the per-channel state
// RAM (one read, one write). Reset (rst, synchronous): clears per-channel valid bits,
// per-bus recovery times, configuration and handshake state together; no clearing pass.
module range_sensor_poll_supervisor #(
  parameter int CHANNELS = 32,
  parameter int PER_BUS  = 8,
  parameter int BUSES    = 4
) (
  input logic           clk,
  input logic           rst,
  rsps_stream_if.sink   req,
  rsps_stream_if.source rsp,
  rsps_stream_if.sink   cfg
);

  import rsps_pkg::*;

  // The channel field is five bits wide, so at most 32 entries can ever be addressed.
  localparam int DEPTH = (CHANNELS < 32) ? CHANNELS : 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Only the first four buses have an enable bit, so only they keep a recovery time.
  localparam int REC_N = (BUSES < 4) ? BUSES : 4;
  localparam int REC_W = (REC_N > 1) ? $clog2(REC_N) : 1;

  // Configuration registers.
  logic [3:0]  bus_enable_mask;
  logic [15:0] stall_timeout_ms;
  logic [15:0] restart_after_ms;
  logic [15:0] reset_after_ms;
  logic [15:0] recover_gap_ms;

  // Bus number of every possible channel, worked out at elaboration.
  logic [4:0] bus_lut [32];
  for (genvar i = 0; i < 32; i++) begin : g_bus_lut
    assign bus_lut[i] = 5'(i / PER_BUS);
  end

  // Stage 1 holds the request whose state entry is being read out of the RAM.
  logic       s1_valid;
  req_t       s1_req;
  logic       s1_vld;
  logic       s1_fwd;
  ch_state_t  s1_fwd_data;

  logic       s1_adv;
  logic       acc;
  logic [AW-1:0] raddr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [$bits(ch_state_t)-1:0] rdata_raw;

  logic [DEPTH-1:0] ch_valid;
  logic [31:0]      last_rec [REC_N];

  // Combinational results of stage 1.
  ch_state_t   cur;
  ch_state_t   nx;
  logic        wr_c;
  logic        rec_wr_c;
  rsp_t        out_c;
  logic        in_range;
  logic [4:0]  bus;
  logic [REC_W-1:0] rec_idx;
  logic        en;
  logic [31:0] dt;
  logic [31:0] dt_rec;
  logic [7:0]  streak_inc;
  logic [5:0]  val;
  logic [7:0]  sum8;

  // The stage advances when the result register is empty or being drained;
  // a new request is taken whenever stage 1 is empty or advancing.
  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign acc       = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign raddr   = AW'(req.data.channel);
  assign wr_addr = AW'(s1_req.channel);
  assign wr_en   = s1_adv && wr_c;

  rsps_ram #(
    .WIDTH ($bits(ch_state_t)),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (nx),
    .re    (acc),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // An entry never written reads as its reset value. When the previous request
  // wrote the same entry in the very cycle this one was read, the RAM returned the
  // old contents, so the written value captured at that edge is used instead.
  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_data;
    end else if (s1_vld) begin
      cur = ch_state_t'(rdata_raw);
    end else begin
      cur = CH_STATE_RST;
    end
  end

  assign in_range = (int'(s1_req.channel) < CHANNELS);
  assign bus      = bus_lut[s1_req.channel];
  assign rec_idx  = REC_W'(bus);
  assign en       = (int'(bus) < BUSES) && (bus < 5'd4) && bus_enable_mask[bus[1:0]];

  assign dt         = s1_req.now_ms - cur.last_good;
  assign dt_rec     = s1_req.now_ms - last_rec[rec_idx];
  assign streak_inc = cur.streak + 8'd1;

  // Clamp a good reading, then either load the filter or run the 3:1 low-pass.
  always_comb begin
    if (s1_req.raw_mm < CLAMP_LO) begin
      val = 6'd0;
    end else if (s1_req.raw_mm > CLAMP_HI) begin
      val = DIST_MAX;
    end else begin
      val = s1_req.raw_mm[5:0];
    end
    sum8 = ({2'b00, cur.filt} << 1) + {2'b00, cur.filt} + {2'b00, val};
  end

  always_comb begin
    nx       = cur;
    wr_c     = 1'b0;
    rec_wr_c = 1'b0;
    out_c    = '0;
    out_c.channel_out   = s1_req.channel;
    out_c.sensor_status = ST_NOSENS;

    if (in_range) begin
      unique case (s1_req.operation)
        OP_POLL: begin
          if (!en) begin
            out_c.data_updated = 1'b1;
            out_c.data_kind    = DK_NOSENS;
          end else if (!cur.online) begin
            out_c.data_updated = 1'b1;
            out_c.data_kind    = cur.ever_online ? DK_DISC : DK_NOSENS;
          end else if (s1_req.bus_error) begin
            wr_c               = 1'b1;
            nx.streak          = streak_inc;
            nx.status          = ST_ERR;
            out_c.data_updated = 1'b1;
            out_c.data_kind    = DK_ERR;
          end else if (s1_req.data_ready) begin
            if (s1_req.result_good) begin
              wr_c      = 1'b1;
              nx.streak = 8'd0;
              if (s1_req.raw_mm == 16'd0 || s1_req.raw_mm > RAW_MAX) begin
                nx.status          = ST_ERR;
                out_c.data_updated = 1'b1;
                out_c.data_kind    = DK_ERR;
              end else begin
                nx.loaded          = 1'b1;
                nx.filt            = cur.loaded ? sum8[7:2] : val;
                nx.status          = ST_OK;
                nx.last_good       = s1_req.now_ms;
                out_c.data_updated = 1'b1;
                out_c.data_kind    = DK_DIST;
                out_c.distance_out = nx.filt;
              end
            end
          end else begin
            // Silent poll: the channel ages, and the block escalates with time.
            wr_c      = 1'b1;
            nx.streak = streak_inc;
            if (dt > {16'd0, stall_timeout_ms}) begin
              nx.status          = ST_STALL;
              out_c.data_updated = 1'b1;
              out_c.data_kind    = DK_STALL;
            end
            if (dt > {16'd0, restart_after_ms} && dt <= {16'd0, reset_after_ms}) begin
              out_c.restart_request = 1'b1;
              nx.last_good          = s1_req.now_ms;
            end
            if (dt > {16'd0, reset_after_ms}) begin
              out_c.hard_reset_request = 1'b1;
            end
            if (streak_hits(streak_inc) && dt_rec > {16'd0, recover_gap_ms}) begin
              out_c.bus_recover_request = 1'b1;
              rec_wr_c                  = 1'b1;
            end
          end
        end
        OP_BRINGUP: begin
          wr_c = 1'b1;
          if (s1_req.outcome_ok) begin
            nx.online      = 1'b1;
            nx.ever_online = 1'b1;
            nx.status      = ST_OK;
            nx.streak      = 8'd0;
            nx.last_good   = s1_req.now_ms;
          end else begin
            nx.online = 1'b0;
            nx.status = ST_NOSENS;
          end
          out_c.data_updated = 1'b1;
          out_c.data_kind    = DK_NOSENS;
        end
        OP_REINIT: begin
          // A re-init answer for a channel that is already offline is ignored.
          if (cur.online) begin
            wr_c = 1'b1;
            if (s1_req.outcome_ok) begin
              nx.filt      = 6'd0;
              nx.loaded    = 1'b0;
              nx.status    = ST_OK;
              nx.last_good = s1_req.now_ms;
            end else begin
              nx.online          = 1'b0;
              nx.status          = ST_DISC;
              out_c.data_updated = 1'b1;
              out_c.data_kind    = DK_DISC;
            end
          end
        end
        default: begin
        end
      endcase
      out_c.sensor_status = nx.status;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      rsp.valid        <= 1'b0;
      ch_valid         <= '0;
      bus_enable_mask  <= 4'd0;
      stall_timeout_ms <= STALL_TMO_RST;
      restart_after_ms <= RESTART_TMO_RST;
      reset_after_ms   <= RESET_TMO_RST;
      recover_gap_ms   <= RECOVER_GAP_RST;
      for (int b = 0; b < REC_N; b++) begin
        last_rec[b] <= 32'd0;
      end
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (wr_en) begin
        ch_valid[wr_addr] <= 1'b1;
      end
      if (s1_adv && rec_wr_c) begin
        last_rec[rec_idx] <= s1_req.now_ms;
      end
      if (cfg.valid) begin
        unique case (cfg.data.index)
          CFG_BUS_ENABLE:  bus_enable_mask  <= cfg.data.value[3:0];
          CFG_STALL_TMO:   stall_timeout_ms <= cfg.data.value;
          CFG_RESTART_TMO: restart_after_ms <= cfg.data.value;
          CFG_RESET_TMO:   reset_after_ms   <= cfg.data.value;
          CFG_RECOVER_GAP: recover_gap_ms   <= cfg.data.value;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_req      <= req.data;
      s1_vld      <= ch_valid[raddr];
      s1_fwd      <= wr_en && (wr_addr == raddr);
      s1_fwd_data <= nx;
    end
    if (s1_adv) begin
      rsp.data <= out_c;
    end
  end

  // A written entry is marked valid from the next cycle on.
  a_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> ch_valid[$past(wr_addr)])
    else $error("state entry not marked valid after write");

  // Only channels that exist ever write the state memory.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> in_range)
    else $error("state write for a channel out of range");

  // Restart and hard reset are requested for disjoint silence spans.
  a_restart_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.restart_request && rsp.data.hard_reset_request))
    else $error("restart and hard reset requested together");

  // The filtered distance never exceeds the clamp ceiling.
  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    s1_adv |-> out_c.distance_out <= DIST_MAX)
    else $error("filtered distance above ceiling");

endmodule

/* bench/tb_range_sensor_poll_supervisor.sv */
`timescale 1ns / 100ps
// Self-checking testbench for range_sensor_poll_supervisor: sensor events in, one report
// out per request, each report predicted in the bench and compared field by field.
// Depends on rsps_pkg, rsps_stream_if and the block's top level.
module tb_range_sensor_poll_supervisor;
  import rsps_pkg::*;

  localparam int CHANNELS = 32;
  localparam int PER_BUS  = 8;
  localparam int BUSES    = 4;

  // The operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Run limit in clock cycles.
  localparam int CYCLE_LIMIT   = 400000;
  // Cycles allowed after the last report before the block counts as idle.
  // The block answers through stage 1 and its result register; this leaves margin.
  localparam int SETTLE_CYCLES = 4;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int LONG_HOLD     = 150;
  // Mismatches beyond this count are still counted but no longer printed.
  localparam int MAX_PRINTED   = 60;

  // Receiver behavior between hold-offs.
  localparam int SINK_ALWAYS   = 0;
  localparam int SINK_RANDOM   = 1;
  localparam int SINK_PERIODIC = 2;

  logic clk;
  logic rst;

  rsps_stream_if #(.payload_t(req_t)) req_if ();
  rsps_stream_if #(.payload_t(rsp_t)) rsp_if ();
  rsps_stream_if #(.payload_t(cfg_t)) cfg_if ();

  range_sensor_poll_supervisor #(
    .CHANNELS(CHANNELS),
    .PER_BUS (PER_BUS),
    .BUSES   (BUSES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // Bench copy of the per-channel sensor state.
  bit          ch_online       [CHANNELS];
  bit          ch_seen         [CHANNELS];
  logic [2:0]  ch_status       [CHANNELS];
  logic [7:0]  ch_streak       [CHANNELS];
  logic [31:0] ch_good_ms      [CHANNELS];
  logic [5:0]  ch_filter       [CHANNELS];
  bit          ch_filter_valid [CHANNELS];
  logic [31:0] bus_recover_ms  [BUSES];

  // Bench copy of the configuration registers.
  logic [3:0]  cur_bus_mask;
  logic [15:0] cur_stall_ms;
  logic [15:0] cur_restart_ms;
  logic [15:0] cur_reset_ms;
  logic [15:0] cur_recover_gap;

  // Reports predicted for requests the block has taken but not yet answered.
  rsp_t sensor_reports_due [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Millisecond tick stamped on every generated request.
  logic [31:0] tick_ms;

  // Sender burst bookkeeping and receiver controls, set by the test tasks.
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  int          sink_mode    = SINK_RANDOM;
  bit          hold_request = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock, cycle counter and watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // A hung handshake or a lost report ends up here.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Applies one accepted sensor event to the bench state and returns
  // the report the block has to produce for it.
  // ---------------------------------------------------------------------------
  function automatic rsp_t sensor_update(req_t ev);
    rsp_t        rep;
    int unsigned ch;
    int unsigned bus;
    int unsigned reading;
    logic [31:0] dt;
    rep = '0;
    ch  = 32'(ev.channel);
    bus = ch / PER_BUS;
    rep.channel_out = ev.channel;
    case (ev.operation)
      OP_POLL: begin
        if (!cur_bus_mask[bus]) begin
          // A disabled bus hides the sensor and leaves its state alone.
          rep.data_updated = 1'b1;
          rep.data_kind    = DK_NOSENS;
        end else if (!ch_online[ch]) begin
          rep.data_updated = 1'b1;
          rep.data_kind    = ch_seen[ch] ? DK_DISC : DK_NOSENS;
        end else if (ev.bus_error) begin
          ch_streak[ch]++;
          ch_status[ch]    = ST_ERR;
          rep.data_updated = 1'b1;
          rep.data_kind    = DK_ERR;
        end else if (ev.data_ready) begin
          // A failed result read changes nothing at all.
          if (ev.result_good) begin
            ch_streak[ch] = '0;
            if (ev.raw_mm == 0 || ev.raw_mm > RAW_MAX) begin
              ch_status[ch]    = ST_ERR;
              rep.data_updated = 1'b1;
              rep.data_kind    = DK_ERR;
            end else begin
              if (ev.raw_mm < CLAMP_LO) begin
                reading = 0;
              end else if (ev.raw_mm > CLAMP_HI) begin
                reading = 32'(CLAMP_HI);
              end else begin
                reading = 32'(ev.raw_mm);
              end
              // The first reading after a clear loads the filter directly.
              if (ch_filter_valid[ch]) begin
                reading = (3 * ch_filter[ch] + reading) / 4;
              end
              ch_filter_valid[ch] = 1'b1;
              ch_filter[ch]       = 6'(reading);
              ch_status[ch]       = ST_OK;
              ch_good_ms[ch]      = ev.now_ms;
              rep.data_updated    = 1'b1;
              rep.data_kind       = DK_DIST;
              rep.distance_out    = 6'(reading);
            end
          end
        end else begin
          // Silent poll: age the channel and raise whatever requests apply.
          dt = ev.now_ms - ch_good_ms[ch];
          ch_streak[ch]++;
          if (dt > cur_stall_ms) begin
            ch_status[ch]    = ST_STALL;
            rep.data_updated = 1'b1;
            rep.data_kind    = DK_STALL;
          end
          if (dt > cur_restart_ms && dt <= cur_reset_ms) begin
            rep.restart_request = 1'b1;
            ch_good_ms[ch]      = ev.now_ms;
          end
          if (dt > cur_reset_ms) begin
            rep.hard_reset_request = 1'b1;
          end
          if (ch_streak[ch] % STREAK_PERIOD == 0 &&
              ev.now_ms - bus_recover_ms[bus] > cur_recover_gap) begin
            rep.bus_recover_request = 1'b1;
            bus_recover_ms[bus]     = ev.now_ms;
          end
        end
      end
      OP_BRINGUP: begin
        if (ev.outcome_ok) begin
          ch_online[ch]  = 1'b1;
          ch_seen[ch]    = 1'b1;
          ch_status[ch]  = ST_OK;
          ch_streak[ch]  = '0;
          ch_good_ms[ch] = ev.now_ms;
        end else begin
          ch_online[ch] = 1'b0;
          ch_status[ch] = ST_NOSENS;
        end
        rep.data_updated = 1'b1;
        rep.data_kind    = DK_NOSENS;
      end
      OP_REINIT: begin
        // Re-init answers only count for a channel that is still online.
        if (ch_online[ch]) begin
          if (ev.outcome_ok) begin
            ch_filter[ch]       = '0;
            ch_filter_valid[ch] = 1'b0;
            ch_status[ch]       = ST_OK;
            ch_good_ms[ch]      = ev.now_ms;
          end else begin
            ch_online[ch]    = 1'b0;
            ch_status[ch]    = ST_DISC;
            rep.data_updated = 1'b1;
            rep.data_kind    = DK_DISC;
          end
        end
      end
      default: begin
      end
    endcase
    rep.sensor_status = ch_status[ch];
    return rep;
  endfunction

  task automatic reset_model();
    for (int c = 0; c < CHANNELS; c++) begin
      ch_online[c]       = 1'b0;
      ch_seen[c]         = 1'b0;
      ch_status[c]       = ST_NOSENS;
      ch_streak[c]       = '0;
      ch_good_ms[c]      = '0;
      ch_filter[c]       = '0;
      ch_filter_valid[c] = 1'b0;
    end
    for (int b = 0; b < BUSES; b++) begin
      bus_recover_ms[b] = '0;
    end
    cur_bus_mask    = '0;
    cur_stall_ms    = STALL_TMO_RST;
    cur_restart_ms  = RESTART_TMO_RST;
    cur_reset_ms    = RESET_TMO_RST;
    cur_recover_gap = RECOVER_GAP_RST;
  endtask

  // ---------------------------------------------------------------------------
  // Report checking. Every report taken from the block is matched against the
  // oldest prediction; a failure is logged and the run carries on.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch({"report field ", name}, got, want);
    end
  endtask

  always @(posedge clk) begin : report_check
    rsp_t due;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (sensor_reports_due.size() == 0) begin
        report_mismatch("report with no request outstanding, channel",
                        32'(rsp_if.data.channel_out), '0);
      end else begin
        due = sensor_reports_due.pop_front();
        check_field("channel_out", 32'(rsp_if.data.channel_out),
                    32'(due.channel_out));
        check_field("data_updated", 32'(rsp_if.data.data_updated),
                    32'(due.data_updated));
        check_field("data_kind", 32'(rsp_if.data.data_kind),
                    32'(due.data_kind));
        check_field("distance_out", 32'(rsp_if.data.distance_out),
                    32'(due.distance_out));
        check_field("sensor_status", 32'(rsp_if.data.sensor_status),
                    32'(due.sensor_status));
        check_field("restart_request", 32'(rsp_if.data.restart_request),
                    32'(due.restart_request));
        check_field("hard_reset_request", 32'(rsp_if.data.hard_reset_request),
                    32'(due.hard_reset_request));
        check_field("bus_recover_request", 32'(rsp_if.data.bus_recover_request),
                    32'(due.bus_recover_request));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Between long hold-offs it follows the mode the current test
  // picks: always ready, randomly ready, or a fixed 4-of-7 pattern. A hold-off
  // is asked for through hold_request and counted down here.
  // ---------------------------------------------------------------------------
  initial begin : report_sink
    int unsigned hold_left;
    int unsigned beat;
    hold_left    = 0;
    beat         = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      beat = (beat + 1) % 7;
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: rsp_if.ready <= 1'b1;
          SINK_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default:     rsp_if.ready <= (beat >= 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge where the block takes it. The
  // sender works in bursts; between bursts it drops valid for a random gap
  // when gaps are on. Valid is never lowered and raised in the same step.
  task automatic send_request(req_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.data  <= ev;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sensor_reports_due.push_back(sensor_update(ev));
  endtask

  // Stops offering requests and waits until every predicted report is back,
  // plus SETTLE_CYCLES for the block to settle.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (sensor_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(logic [2:0] idx, logic [15:0] val);
    wait_idle();
    cfg_if.data  <= '{index: idx, value: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_BUS_ENABLE:  cur_bus_mask    = val[3:0];
      CFG_STALL_TMO:   cur_stall_ms    = val;
      CFG_RESTART_TMO: cur_restart_ms  = val;
      CFG_RESET_TMO:   cur_reset_ms    = val;
      CFG_RECOVER_GAP: cur_recover_gap = val;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Only the low four bits of the mask count; the upper bits are random.
  task automatic set_bus_mask(logic [3:0] mask);
    write_register(CFG_BUS_ENABLE, {12'($urandom), mask});
  endtask

  task automatic set_thresholds(logic [15:0] stall, logic [15:0] restart,
                                logic [15:0] hard, logic [15:0] gap);
    write_register(CFG_STALL_TMO, stall);
    write_register(CFG_RESTART_TMO, restart);
    write_register(CFG_RESET_TMO, hard);
    write_register(CFG_RECOVER_GAP, gap);
  endtask

  // ---------------------------------------------------------------------------
  // Request builders.
  // ---------------------------------------------------------------------------
  function automatic req_t make_event(logic [1:0] op, logic [4:0] ch, logic berr,
                                      logic rdy, logic good, logic [15:0] mm, logic ok);
    req_t ev;
    ev.operation   = op;
    ev.channel     = ch;
    ev.now_ms      = tick_ms;
    ev.bus_error   = berr;
    ev.data_ready  = rdy;
    ev.result_good = good;
    ev.raw_mm      = mm;
    ev.outcome_ok  = ok;
    return ev;
  endfunction

  task automatic send_reading(logic [4:0] ch, logic [15:0] mm);
    send_request(make_event(OP_POLL, ch, 1'b0, 1'b1, 1'b1, mm, 1'($urandom)));
  endtask

  // Mostly well-formed sensor traffic: good readings, silent polls, bus errors
  // and bring-up/re-init answers, with a few fully random requests mixed in.
  // Fields that the chosen operation ignores still carry random values.
  function automatic req_t random_event(logic [4:0] ch);
    req_t        ev;
    int unsigned pick;
    ev = make_event(OP_POLL, ch, 1'($urandom), 1'($urandom), 1'($urandom),
                    16'($urandom_range(0, 220)), ($urandom_range(0, 99) < 80));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.bus_error   = 1'b0;
      ev.data_ready  = 1'b1;
      ev.result_good = 1'b1;
      if ($urandom_range(0, 9) == 0) ev.raw_mm = 16'($urandom);
    end else if (pick < 65) begin
      ev.bus_error  = 1'b0;
      ev.data_ready = 1'b0;
    end else if (pick < 72) begin
      ev.bus_error = 1'b1;
    end else if (pick < 77) begin
      ev.bus_error   = 1'b0;
      ev.data_ready  = 1'b1;
      ev.result_good = 1'b0;
    end else if (pick < 86) begin
      ev.operation = OP_BRINGUP;
    end else if (pick < 93) begin
      ev.operation = OP_REINIT;
    end else if (pick < 96) begin
      ev.operation = OP_UNUSED;
    end else begin
      ev.operation = 2'($urandom);
      ev.raw_mm    = 16'($urandom);
    end
    return ev;
  endfunction

  // Brings up four hot channels, then sends random traffic aimed mostly at them
  // so that their state runs deep. The tick advances by up to step_max per
  // request, with rare long jumps and rare jumps to any value.
  task automatic run_traffic(int count, int unsigned step_max);
    logic [4:0]  hot [4];
    logic [4:0]  ch;
    int unsigned pick;
    for (int k = 0; k < 4; k++) begin
      hot[k] = 5'($urandom_range(0, CHANNELS - 1));
      send_request(make_event(OP_BRINGUP, hot[k], 1'($urandom), 1'($urandom),
                              1'($urandom), 16'($urandom), 1'b1));
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        tick_ms = $urandom();
      end else if (pick < 4) begin
        tick_ms += $urandom_range(0, 70000);
      end else begin
        tick_ms += $urandom_range(0, step_max);
      end
      if ($urandom_range(0, 9) < 8) begin
        ch = hot[$urandom_range(0, 3)];
      end else begin
        ch = 5'($urandom_range(0, CHANNELS - 1));
      end
      send_request(random_event(ch));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Straight out of reset every bus is disabled: polls report no sensor, but
  // bring-up answers still land in the channel state.
  task automatic test_reset_state();
    logic [4:0] ch;
    ch      = 5'($urandom_range(0, CHANNELS - 1));
    tick_ms = 32'd500;
    send_reading(ch, 16'd30);
    send_request(make_event(OP_UNUSED, 5'd31, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1));
    send_request(make_event(OP_BRINGUP, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send_reading(ch, 16'd30);
  endtask

  // Walks one channel through the branches: range limits and clamping, the filter
  // load and low-pass, a failed read, a bus error, the stall, restart and hard-reset
  // requests, re-init success and failure, and polls of a lost and a never-seen sensor.
  task automatic test_directed();
    logic [4:0] ch;
    logic [4:0] other;
    ch    = 5'($urandom_range(0, CHANNELS - 1));
    other = ch ^ 5'd8;
    set_bus_mask(4'hF);
    set_thresholds(16'd20, 16'd100, 16'd400, 16'd50);
    tick_ms = 32'd1000;
    send_request(make_event(OP_BRINGUP, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send_reading(ch, 16'd0);
    tick_ms += 1;
    send_reading(ch, 16'd1);
    send_reading(ch, 16'd200);
    send_reading(ch, 16'd201);
    send_reading(ch, 16'hFFFF);
    send_reading(ch, 16'd4);
    send_reading(ch, 16'd51);
    send_request(make_event(OP_POLL, ch, 1'b0, 1'b1, 1'b0, 16'd77, 1'b1));
    send_request(make_event(OP_POLL, ch, 1'b1, 1'b1, 1'b1, 16'd40, 1'b0));
    // Silence: below the stall limit, past it, into restart, then hard reset.
    tick_ms += 10;
    send_request(make_event(OP_POLL, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
    tick_ms += 30;
    send_request(make_event(OP_POLL, ch, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0));
    tick_ms += 150;
    send_request(make_event(OP_POLL, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    tick_ms += 500;
    send_request(make_event(OP_POLL, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
    send_request(make_event(OP_REINIT, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send_reading(ch, 16'd40);
    send_request(make_event(OP_REINIT, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
    send_reading(ch, 16'd40);
    send_request(make_event(OP_REINIT, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send_reading(other, 16'd40);
    send_request(make_event(OP_BRINGUP, other, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
    send_request(make_event(OP_UNUSED, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
  endtask

  task automatic test_steady_traffic();
    sink_mode = SINK_RANDOM;
    set_bus_mask(4'hF);
    set_thresholds(16'd20, 16'd100, 16'd400, 16'd50);
    run_traffic(100, 30);
  endtask

  // The receiver holds off for a long stretch while the sender offers requests
  // back to back, so the block fills up and has to stall its input. Afterwards
  // the sender waits until every report is back before going on.
  task automatic test_backpressure();
    wait_idle();
    sink_mode    = SINK_ALWAYS;
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    run_traffic(80, 40);
    gaps_on = 1'b1;
    wait_idle();
  endtask

  // All limits at zero: any silence stalls and asks for a hard reset, a restart
  // can never be asked, and recovery is throttled only by equal ticks.
  task automatic test_zero_thresholds();
    sink_mode = SINK_PERIODIC;
    set_bus_mask(4'hF);
    set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(150, 3);
  endtask

  task automatic test_max_thresholds();
    sink_mode = SINK_ALWAYS;
    set_bus_mask(4'hF);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(150, 30000);
  endtask

  // Reset-value limits with the tick running across its wrap point.
  task automatic test_tick_wrap();
    sink_mode = SINK_PERIODIC;
    set_bus_mask(4'hF);
    set_thresholds(STALL_TMO_RST, RESTART_TMO_RST, RESET_TMO_RST, RECOVER_GAP_RST);
    tick_ms = 32'hFFFF_FC00;
    run_traffic(200, 300);
  endtask

  // A long run of silent polls and bus errors on one channel drives its error
  // streak past 255 so the counter wraps. A neighbor on the same bus shares the
  // recovery throttle, and the short gap lets only some recoveries through.
  task automatic test_streak_wrap();
    logic [4:0] ch;
    logic [4:0] ch_near;
    logic [4:0] target;
    sink_mode = SINK_RANDOM;
    set_bus_mask(4'hF);
    set_thresholds(16'd5, 16'd40, 16'hFFFF, 16'd15);
    ch      = 5'($urandom_range(0, CHANNELS - 1));
    ch_near = ch ^ 5'd1;
    send_request(make_event(OP_BRINGUP, ch, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send_request(make_event(OP_BRINGUP, ch_near, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    for (int i = 0; i < 340; i++) begin
      tick_ms += $urandom_range(1, 3);
      target = ($urandom_range(0, 4) == 0) ? ch_near : ch;
      send_request(make_event(OP_POLL, target, ($urandom_range(0, 9) == 0), 1'b0,
                              1'($urandom), 16'($urandom), 1'($urandom)));
    end
  endtask

  // Some buses disabled: their channels must read as absent whatever happens.
  task automatic test_partial_buses();
    sink_mode = SINK_RANDOM;
    set_bus_mask(4'($urandom_range(1, 14)));
    set_thresholds(16'd30, 16'd150, 16'd600, 16'd100);
    run_traffic(100, 50);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    tick_ms      = '0;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_steady_traffic();
    test_backpressure();
    test_zero_thresholds();
    test_max_thresholds();
    test_tick_wrap();
    test_streak_wrap();
    test_partial_buses();

    // Drain, then give the block time to show any report nobody asked for.
    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sensor_reports_due.size() != 0) begin
      report_mismatch("reports never delivered", sensor_reports_due.size(), '0);
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
